// File: rtl/block_crc_symbol_framer_macros.svh
// ----------------------------------------------------------------------------
// block crc symbol framer assertion macros
// shared assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BLOCK_CRC_SYMBOL_FRAMER_MACROS_SVH
`define BLOCK_CRC_SYMBOL_FRAMER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define BCSF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BCSF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BCSF_ASSERT_IMP(label, ante, cons, msg)
`define BCSF_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/bcsf_pkg.sv
// ----------------------------------------------------------------------------
// bcsf_pkg
// types, constants and framing functions for the block crc symbol framer
// ----------------------------------------------------------------------------
package bcsf_pkg;

   localparam int POS_W = 7;
   localparam logic [POS_W-1:0] BLOCK_BYTES = 7'd64;
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [2:0] PAD_MARK = 3'h4;

   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [3:0] high;
      logic [3:0] mid;
      logic [3:0] low;
   } sym3_type;

   typedef struct packed {
      logic [1:0] byte_count;
      sym3_type   sym_a;
      sym3_type   sym_b;
      logic       last;
   } result_type;

   typedef struct packed {
      logic             flushing;
      logic             take;
      logic [POS_W-1:0] block_pos;
   } fstat_type;

   // crc-8, msb first, no final xor
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // chunk bits reversed onto 3..1, clock bit on 0
   function automatic logic [3:0] make_nibble(input logic [2:0] chunk, input logic par);
      return {chunk[0], chunk[1], chunk[2], par};
   endfunction

   // par is the parity of the byte position, which equals that of its first symbol
   function automatic sym3_type frame_byte(input logic [7:0] b, input logic mark,
                                           input logic par);
      sym3_type   s;
      logic [2:0] m;
      m = mark ? PAD_MARK : 3'd0;
      s.high = make_nibble({1'b0, b[7:6]} | m, par);
      s.mid  = make_nibble(b[5:3] | m, ~par);
      s.low  = make_nibble(b[2:0] | m, par);
      return s;
   endfunction

endpackage

// File: rtl/block_crc_symbol_framer.sv
// ----------------------------------------------------------------------------
// block_crc_symbol_framer
// frames data bytes into crc-8 protected blocks of 4-bit port symbols
// ----------------------------------------------------------------------------
// Each data byte becomes three port nibbles (bits 7..6, 5..3, 2..0), chunk
// bits reversed onto nibble bits 3..1 and a toggling clock bit on bit 0.
// After 64 data bytes a crc-8 byte (poly 0x07, init 0) closes the block.
// A flush request appends the crc of a partial block, then zero pad bytes
// up to 65 bytes, the first pad byte marked with 0x04 in every chunk; the
// final response of a flush has tlast set. A response carries one or two
// framed bytes. A data byte gives one response, so the block sustains one
// data transaction per clock unless a flush runs or the response stalls.
// A flush gives ceil((65 - n) / 2) responses (n = bytes pending in the
// block, 33 when the block is empty), one per cycle from the flush
// sequencer unless the response stalls; no new request is consumed until
// the last is loaded. Input register, framing logic, response register.
// ----------------------------------------------------------------------------
module block_crc_symbol_framer
   import bcsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] req_type
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] byte_count, [5:2] sym_a_high,
                                    // [9:6] sym_a_mid, [13:10] sym_a_low,
                                    // [17:14] sym_b_high, [21:18] sym_b_mid,
                                    // [25:22] sym_b_low, [31:26] zero
   output logic        rsp_tlast    // last
);

`include "block_crc_symbol_framer_macros.svh"

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       out_ready;
   logic       res_valid;
   result_type res;
   result_type rsp_res;
   fstat_type  stat;

   // unpack request transaction
   assign req_item.req_type  = req_tuser;
   assign req_item.data_byte = req_tdata;

   // input register, frees up as soon as the framer consumes the item
   bcsf_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (stat.take),
      .item_valid (item_valid),
      .item       (item)
   );

   // block state, crc and flush sequencing
   bcsf_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_ready  (out_ready),
      .res_valid  (res_valid),
      .res        (res),
      .stat       (stat)
   );

   // response register
   bcsf_egress u_egress (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   // pack response transaction, lowest field first
   assign rsp_tdata = {6'd0,
                       rsp_res.sym_b.low, rsp_res.sym_b.mid, rsp_res.sym_b.high,
                       rsp_res.sym_a.low, rsp_res.sym_a.mid, rsp_res.sym_a.high,
                       rsp_res.byte_count};
   assign rsp_tlast = rsp_res.last;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // no request consumed while the pad sequence is running
   `BCSF_ASSERT_IMP(a_no_take_in_flush, stat.flushing, !stat.take, "item taken during flush")

   // block position never reaches the block length
   `BCSF_ASSERT_IMP(a_pos_in_range, 1'b1, stat.block_pos < BLOCK_BYTES, "block position overflow")

   // a single-byte response carries an empty second byte
   `BCSF_ASSERT_IMP(a_single_b_zero, rsp_tvalid && (rsp_tdata[1:0] == 2'd1),
                    rsp_tdata[25:14] == 12'd0, "second byte not cleared")

   // a loaded final flush response ends the flush sequence
   `BCSF_ASSERT_NXT(a_last_ends_flush, res_valid && out_ready && res.last,
                    !stat.flushing && (stat.block_pos == '0), "flush did not end")

endmodule

// File: rtl/bcsf_ingress.sv
// ----------------------------------------------------------------------------
// bcsf_ingress
// input register stage holding one request transaction
// ----------------------------------------------------------------------------
module bcsf_ingress
   import bcsf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  item_type req_item,
   input  logic     take,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/bcsf_framer.sv
// ----------------------------------------------------------------------------
// bcsf_framer
// block position, running crc, flush sequencer and symbol framing
// ----------------------------------------------------------------------------
module bcsf_framer
   import bcsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       out_ready,
   output logic       res_valid,
   output result_type res,
   output fstat_type  stat
);

   logic [POS_W-1:0] k_ff, k_in;
   logic [7:0]       crc_ff, crc_in;
   logic             flush_ff, flush_in;
   logic [POS_W-1:0] fp_ff, fp_in;
   logic             crc_pend_ff, crc_pend_in;
   logic             mark_pend_ff, mark_pend_in;

   logic [POS_W-1:0] pos0;
   logic             crc_pend, mark_pend, is_flush, load, take;
   logic [7:0]       crc_next;
   logic             blk_done, two, fl_last;
   logic [7:0]       b0, b1;
   logic             m0, m1;

   assign pos0      = flush_ff ? fp_ff : k_ff;
   assign crc_pend  = flush_ff ? crc_pend_ff : (k_ff != '0);
   assign mark_pend = flush_ff ? mark_pend_ff : (k_ff == '0);
   assign is_flush  = flush_ff || (item.req_type == REQ_FLUSH);
   assign crc_next  = crc_update(crc_ff, item.data_byte);
   assign blk_done  = (k_ff == BLOCK_BYTES - 7'd1);
   assign fl_last   = (pos0 >= BLOCK_BYTES - 7'd1);

   assign res_valid = flush_ff || item_valid;
   assign load      = res_valid && out_ready;
   assign take      = item_valid && !flush_ff && out_ready;

   always_comb begin
      if (is_flush) begin
         b0  = crc_pend ? crc_ff : 8'd0;
         m0  = !crc_pend && mark_pend;
         b1  = 8'd0;
         m1  = crc_pend;
         two = (pos0 < BLOCK_BYTES);
      end else begin
         b0  = item.data_byte;
         m0  = 1'b0;
         b1  = crc_next;
         m1  = 1'b0;
         two = blk_done;
      end
      res.byte_count = two ? 2'd2 : 2'd1;
      res.sym_a      = frame_byte(b0, m0, pos0[0]);
      res.sym_b      = two ? frame_byte(b1, m1, ~pos0[0]) : '0;
      res.last       = is_flush && fl_last;
   end

   always_comb begin
      k_in         = k_ff;
      crc_in       = crc_ff;
      flush_in     = flush_ff;
      fp_in        = fp_ff;
      crc_pend_in  = crc_pend_ff;
      mark_pend_in = mark_pend_ff;
      if (load) begin
         if (is_flush) begin
            if (fl_last) begin
               flush_in = 1'b0;
               k_in     = '0;
               crc_in   = '0;
            end else begin
               flush_in     = 1'b1;
               fp_in        = pos0 + 7'd2;
               crc_pend_in  = 1'b0;
               mark_pend_in = 1'b0;
            end
         end else begin
            k_in   = blk_done ? '0 : k_ff + 7'd1;
            crc_in = blk_done ? '0 : crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         crc_ff       <= '0;
         flush_ff     <= 1'b0;
         crc_pend_ff  <= 1'b0;
         mark_pend_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         crc_ff       <= crc_in;
         flush_ff     <= flush_in;
         crc_pend_ff  <= crc_pend_in;
         mark_pend_ff <= mark_pend_in;
      end
      fp_ff <= fp_in;
   end

   assign stat.flushing  = flush_ff;
   assign stat.take      = take;
   assign stat.block_pos = k_ff;

endmodule

// File: rtl/bcsf_egress.sv
// ----------------------------------------------------------------------------
// bcsf_egress
// result register toward the response channel
// ----------------------------------------------------------------------------
module bcsf_egress
   import bcsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       out_ready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (res_valid && out_ready) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule
